### rtl/wildcard_byte_pattern_scanner_core_macros.svh
// Assertion macros for the scanner core RTL.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_CORE_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_CORE_MACROS_SVH
`ifndef SYNTH
`define WBPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define WBPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define WBPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define WBPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/wbps_pkg.sv
// Types, register codes and pattern helpers for the byte pattern scanner.
package wbps_pkg;

	localparam int PAT_BYTES = 16;
	localparam int OFS_W     = 48;
	localparam int CNT_W     = 16;
	localparam int LEN_CFG_W = 5;
	localparam int MIN_LEN   = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 64;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PAT_LO      = 3'd0,
		CFG_PAT_HI      = 3'd1,
		CFG_WILD_MASK   = 3'd2,
		CFG_PAT_LEN     = 3'd3,
		CFG_START_OFS   = 3'd4,
		CFG_END_LIMIT   = 3'd5,
		CFG_MAX_MATCHES = 3'd6
	} cfg_reg_e;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       region_first;
		logic       new_scan;
	} src_beat_t;

	typedef struct packed {
		logic [OFS_W-1:0] match_offset;
		logic             limit_reached;
	} res_beat_t;

	typedef struct packed {
		logic       active;
		logic       wild;
		logic [7:0] want;
	} cell_ctl_t;

	function automatic logic [7:0] pat_byte(input logic [63:0] lo, input logic [63:0] hi,
		input logic [7:0] idx);
		logic [7:0] r;
		if (idx < 8'd8) begin
			r = lo[idx[2:0]*8 +: 8];
		end else if (idx < 8'(PAT_BYTES)) begin
			r = hi[idx[2:0]*8 +: 8];
		end else begin
			r = '0;
		end
		return r;
	endfunction

	function automatic logic pat_wild(input logic [PAT_BYTES-1:0] mask, input logic [7:0] idx);
		logic r;
		if (idx < 8'(PAT_BYTES)) begin
			r = mask[idx[3:0]];
		end else begin
			r = 1'b0;
		end
		return r;
	endfunction

endpackage

### rtl/wildcard_byte_pattern_scanner_core.sv
// Wildcard byte pattern scanner: a chain of window cells, range gate, match count.
// A result beat is held in the window cells and s1 stage registers, then in the output register.
// Throughput: 1 byte per cycle while src_stall is low; the compare across the cell chain is parallel.
// A full output register with res_stall high holds the compare stage and, while it is full, stalls src.
// Reset (arst_n low): window, offset, match count and stop flag clear; pattern_length is 2,
// all other configuration registers 0. No clearing pass; ready right after reset.
`include "wildcard_byte_pattern_scanner_core_macros.svh"

module wildcard_byte_pattern_scanner_core #(
	parameter int MAX_PATTERN = 16,
	parameter int OFFSET_BITS = 48
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                src_valid,
	output logic                                src_stall,
	input  wbps_pkg::src_beat_t                 src_beat,
	output logic                                res_valid,
	input  logic                                res_stall,
	output wbps_pkg::res_beat_t                 res_beat,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  wbps_pkg::cfg_idx_t                  cfg_index,
	input  logic [wbps_pkg::CFG_DAT_W-1:0]      cfg_data
);
	import wbps_pkg::*;

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int CMP_W = (OFFSET_BITS > OFS_W) ? OFFSET_BITS : OFS_W;

	// configuration
	logic [63:0]            pat_lo_q;
	logic [63:0]            pat_hi_q;
	logic [PAT_BYTES-1:0]   wild_q;
	logic [LEN_CFG_W-1:0]   pat_len_q;
	logic [OFS_W-1:0]       start_q;
	logic [OFS_W-1:0]       end_q;
	logic [CNT_W-1:0]       max_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			wild_q    <= '0;
			pat_len_q <= LEN_CFG_W'(MIN_LEN);
			start_q   <= '0;
			end_q     <= '0;
			max_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PAT_LO:      pat_lo_q  <= cfg_data;
				CFG_PAT_HI:      pat_hi_q  <= cfg_data;
				CFG_WILD_MASK:   wild_q    <= cfg_data[PAT_BYTES-1:0];
				CFG_PAT_LEN:     pat_len_q <= cfg_data[LEN_CFG_W-1:0];
				CFG_START_OFS:   start_q   <= cfg_data[OFS_W-1:0];
				CFG_END_LIMIT:   end_q     <= cfg_data[OFS_W-1:0];
				CFG_MAX_MATCHES: max_q     <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// effective pattern length, clamped to [2, MAX_PATTERN]
	logic [LEN_W-1:0] len_eff;

	always_comb begin
		if (int'(pat_len_q) < MIN_LEN) begin
			len_eff = LEN_W'(MIN_LEN);
		end else if (int'(pat_len_q) > MAX_PATTERN) begin
			len_eff = LEN_W'(MAX_PATTERN);
		end else begin
			len_eff = LEN_W'(pat_len_q);
		end
	end

	// handshake and stage control
	logic valid_s1;
	logic hold;
	logic adv;
	logic accept;

	assign hold      = res_valid && res_stall;
	assign adv       = valid_s1 && !hold;
	assign src_stall = valid_s1 && hold;
	assign accept    = src_valid && !src_stall;

	// offset and range gate, evaluated on accept
	logic [OFFSET_BITS-1:0] region_offset_q;
	logic [OFFSET_BITS-1:0] cur;
	logic [OFFSET_BITS-1:0] lm1;
	logic [OFFSET_BITS-1:0] s;
	logic [CMP_W-1:0]       s_x;
	logic                   gate;

	assign cur = src_beat.region_first ? '0 : region_offset_q;
	assign lm1 = OFFSET_BITS'(len_eff - 1'b1);
	assign s   = cur - lm1;
	assign s_x = CMP_W'(s);
	assign gate = (cur >= lm1) && (s_x >= CMP_W'(start_q))
		&& ((end_q == '0) || (s_x < CMP_W'(end_q)));

	logic             gate_s1;
	logic             fresh_s1;
	logic [OFS_W-1:0] ofs_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_offset_q <= '0;
			valid_s1        <= 1'b0;
		end else begin
			if (accept) begin
				region_offset_q <= cur + 1'b1;
				valid_s1        <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gate_s1  <= gate;
			fresh_s1 <= src_beat.new_scan;
			ofs_s1   <= OFS_W'(s);
		end
	end

	// cell chain; cell k holds the byte k places back
	logic [7:0]             win [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] hits;

	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		localparam logic [LEN_W-1:0] K = LEN_W'(k);
		logic [LEN_W-1:0] p;
		logic [7:0]       d;
		cell_ctl_t        ctl;

		assign p          = len_eff - K - 1'b1;
		assign ctl.active = K < len_eff;
		assign ctl.wild   = (k != 0) && pat_wild(wild_q, 8'(p));
		assign ctl.want   = pat_byte(pat_lo_q, pat_hi_q, 8'(p));

		if (k == 0) begin : g_head
			assign d = src_beat.data_byte;
		end else begin : g_body
			assign d = src_beat.region_first ? 8'h00 : win[k-1];
		end

		wbps_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (accept),
			.d        (d),
			.ctl      (ctl),
			.q        (win[k]),
			.hit      (hits[k])
		);
	end

	// match count and stop
	logic [CNT_W-1:0] found_count_q;
	logic             stopped_q;
	logic [CNT_W-1:0] fc_base;
	logic [CNT_W-1:0] fc_next;
	logic             st_base;
	logic             produce;
	logic             reached;

	assign fc_base = fresh_s1 ? '0 : found_count_q;
	assign st_base = fresh_s1 ? 1'b0 : stopped_q;
	assign fc_next = fc_base + 1'b1;
	assign produce = valid_s1 && gate_s1 && !st_base && (&hits);
	assign reached = (max_q != '0) && (fc_next >= max_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_count_q <= '0;
			stopped_q     <= 1'b0;
		end else if (adv) begin
			found_count_q <= produce ? fc_next : fc_base;
			stopped_q     <= st_base || (produce && reached);
		end
	end

	// output register
	logic      res_valid_q;
	res_beat_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && produce) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && produce) begin
			res_q.match_offset  <= ofs_s1;
			res_q.limit_reached <= reached;
		end
	end

	assign res_valid = res_valid_q;
	assign res_beat  = res_q;

	`WBPS_ASSERT_NXT(a_limit_stops, clk, arst_n, adv && produce && reached, stopped_q, "limit beat did not stop scan")
	`WBPS_ASSERT_IMP(a_no_res_stopped, clk, arst_n, adv && stopped_q && !fresh_s1, !produce, "result while stopped")
	`WBPS_ASSERT_NXT(a_cnt_step, clk, arst_n, adv && produce, found_count_q == $past(fc_next), "match count step")
	`WBPS_ASSERT_NXT(a_win_clear, clk, arst_n, accept && src_beat.region_first, win[1] == 8'h00, "window not cleared")

endmodule

### rtl/wbps_cell.sv
// One window cell: holds a byte, passes it on, compares it to its pattern byte.
module wbps_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift_en,
	input  logic [7:0]          d,
	input  wbps_pkg::cell_ctl_t ctl,
	output logic [7:0]          q,
	output logic                hit
);
	import wbps_pkg::*;

	logic [7:0] win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (shift_en) begin
			win_q <= d;
		end
	end

	assign q   = win_q;
	assign hit = !ctl.active || ctl.wild || (win_q == ctl.want);

endmodule
